>>> design/lcwm_pkg.sv
// ----------------------------------------------------------------------------
// lcwm_pkg: shared types and constants of the command line word matcher
// Holds register indexes, result event codes, the word tracking phases and
// the item type that travels from the front end to the back end.
// ----------------------------------------------------------------------------
package lcwm_pkg;

    localparam int LINE_BUFFER_LEN_DEF = 32;
    localparam int NAME_LEN_DEF        = 8;

    localparam int NAME_BYTES_MAX = 8;
    localparam int NAME_W         = NAME_BYTES_MAX * 8;
    localparam int NUM_NAMES      = 6;
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [7:0] TERMINATOR_RST = 8'h0A;
    localparam logic [7:0] SPACE_CHAR     = 8'h20;
    localparam logic [7:0] PRINT_LOW      = 8'h20;
    localparam logic [7:0] PRINT_HIGH     = 8'h7E;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = NAME_W;

    localparam logic [CFG_INDEX_W-1:0] REG_TERMINATOR = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_CMD_COUNT  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_NAME_0     = 3'd2;

    typedef enum logic [1:0] {
        EV_NONE    = 2'd0,
        EV_EMPTY   = 2'd1,
        EV_MATCH   = 2'd2,
        EV_NOMATCH = 2'd3
    } line_event_t;

    typedef enum logic [1:0] {
        PH_BEFORE = 2'd0,
        PH_INSIDE = 2'd1,
        PH_AFTER  = 2'd2
    } word_phase_t;

    typedef logic [NUM_NAMES-1:0][NAME_W-1:0] name_array_t;

    // One classified byte as seen by the back end.
    typedef struct packed {
        logic              line_end;
        logic              has_word;
        logic [NAME_W-1:0] word;
        logic              dropped;
    } front_item_t;

endpackage

>>> design/line_command_word_matcher_top.sv
// ----------------------------------------------------------------------------
// line_command_word_matcher_top: serial command line word matcher
// Takes received bytes, tracks the first word of each line and reports at
// the line end whether that word names one of the configured commands.
// ----------------------------------------------------------------------------
// Every accepted byte gives exactly one result item. Bytes are taken one per
// clock cycle when the result side keeps up. A result passes through the
// queue entry and then the result register before it is presented on the
// result port, where it is held until taken. The front end updates the
// line state for each byte, a two-entry queue follows it, and the back end
// compares the word against all six names in parallel before the result
// register. The front end keeps taking bytes while a result waits at the
// output, until the queue is full. A result item carries
// an event code (no line end, empty line, matched command, unmatched word),
// the lowest matching name index, and a flag for a printable byte that was
// lost because the line already held LINE_BUFFER_LEN bytes. Words are
// compared on their first NAME_LEN characters; a zero byte in a name ends the
// compare. Configuration is written through cfg_wr_en, cfg_index and
// cfg_wdata while no item is in flight: index 0 is the terminator byte,
// index 1 the number of names in use (values above six act as six), and
// indexes 2 to 7 the names, first character in the lowest byte.
// ----------------------------------------------------------------------------
module line_command_word_matcher_top
    import lcwm_pkg::*;
#(
    parameter int LINE_BUFFER_LEN = LINE_BUFFER_LEN_DEF,
    parameter int NAME_LEN        = NAME_LEN_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic [7:0]             s_rx_byte,
    output logic                   m_valid,
    input  logic                   m_ready,
    output logic [1:0]             m_line_event,
    output logic [2:0]             m_match_index,
    output logic                   m_byte_dropped
);

    // Configuration registers. The names live in one packed array so that
    // the back end sees every name at a fixed place.
    logic [7:0]  terminator_reg;
    logic [2:0]  cmd_count_reg;
    name_array_t names_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            terminator_reg <= TERMINATOR_RST;
            cmd_count_reg  <= '0;
            names_reg      <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == REG_TERMINATOR) begin
                terminator_reg <= cfg_wdata[7:0];
            end
            if (cfg_index == REG_CMD_COUNT) begin
                cmd_count_reg <= cfg_wdata[2:0];
            end
            for (int i = 0; i < NUM_NAMES; i++) begin
                if (cfg_index == REG_NAME_0 + CFG_INDEX_W'(i)) begin
                    names_reg[i] <= cfg_wdata;
                end
            end
        end
    end

    // Front end to queue.
    logic        fq_valid;
    logic        fq_ready;
    front_item_t fq_item;

    // Queue to back end.
    logic        qb_valid;
    logic        qb_ready;
    front_item_t qb_item;

    lcwm_front #(
        .LINE_BUFFER_LEN (LINE_BUFFER_LEN),
        .NAME_LEN        (NAME_LEN)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .terminator (terminator_reg),
        .in_valid   (s_valid),
        .in_ready   (s_ready),
        .in_byte    (s_rx_byte),
        .item_valid (fq_valid),
        .item_ready (fq_ready),
        .item       (fq_item)
    );

    lcwm_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_item  (fq_item),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_item   (qb_item)
    );

    lcwm_back #(
        .NAME_LEN (NAME_LEN)
    ) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd_count      (cmd_count_reg),
        .names          (names_reg),
        .item_valid     (qb_valid),
        .item_ready     (qb_ready),
        .item           (qb_item),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_line_event   (m_line_event),
        .m_match_index  (m_match_index),
        .m_byte_dropped (m_byte_dropped)
    );

    // Every accepted byte must enter the queue in the same cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> (fq_valid && fq_ready))
        else $error("accepted byte did not enter the queue");

    // A terminator byte produces a line end item and never a drop flag.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_rx_byte == terminator_reg))
            |-> (fq_item.line_end && !fq_item.dropped))
        else $error("terminator byte was not classified as a line end");

    // A dropped byte is never reported together with a line end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_byte_dropped) |-> (m_line_event == EV_NONE))
        else $error("drop flag reported with a line end");

    // The index is only set for a match, and then names an existing command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_line_event == EV_MATCH) ? (m_match_index < 3'(NUM_NAMES))
                                                 : (m_match_index == '0)))
        else $error("match index inconsistent with the line event");

endmodule

>>> design/lcwm_front.sv
// ----------------------------------------------------------------------------
// lcwm_front: byte classifier and line state
// Sorts each byte into terminator, printable or ignored, keeps the line fill
// count and the first word, and hands one classified item per byte onward.
// ----------------------------------------------------------------------------
module lcwm_front
    import lcwm_pkg::*;
#(
    parameter int LINE_BUFFER_LEN = LINE_BUFFER_LEN_DEF,
    parameter int NAME_LEN        = NAME_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [7:0]  terminator,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  in_byte,
    output logic        item_valid,
    input  logic        item_ready,
    output front_item_t item
);

    localparam int CW = $clog2(LINE_BUFFER_LEN + 1);
    localparam int LW = $clog2(NAME_LEN + 1);

    word_phase_t        phase_reg, phase_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [LW-1:0]      len_reg, len_next;
    logic [NAME_W-1:0]  word_reg, word_next;

    logic accept;
    logic is_term;
    logic is_print;
    logic is_space;
    logic has_room;

    assign in_ready   = item_ready;
    assign accept     = in_valid && item_ready;
    assign item_valid = accept;

    assign is_term  = (in_byte == terminator);
    assign is_print = (in_byte >= PRINT_LOW) && (in_byte <= PRINT_HIGH);
    assign is_space = (in_byte == SPACE_CHAR);
    assign has_room = (count_reg < CW'(LINE_BUFFER_LEN));

    // Word phase: skip leading spaces, enter the word, close it at a space.
    always_comb begin
        phase_next = phase_reg;
        if (accept) begin
            if (is_term) begin
                phase_next = PH_BEFORE;
            end else if (is_print && has_room) begin
                case (phase_reg)
                    PH_BEFORE: phase_next = is_space ? PH_BEFORE : PH_INSIDE;
                    PH_INSIDE: phase_next = is_space ? PH_AFTER : PH_INSIDE;
                    PH_AFTER:  phase_next = PH_AFTER;
                    default:   phase_next = PH_BEFORE;
                endcase
            end
        end
    end

    // Line fill count, kept word characters and the item handed onward.
    always_comb begin
        count_next    = count_reg;
        len_next      = len_reg;
        word_next     = word_reg;
        item.line_end = 1'b0;
        item.has_word = (phase_reg != PH_BEFORE);
        item.word     = word_reg;
        item.dropped  = 1'b0;
        if (accept) begin
            if (is_term) begin
                item.line_end = 1'b1;
                count_next    = '0;
                len_next      = '0;
                word_next     = '0;
            end else if (is_print) begin
                if (has_room) begin
                    count_next = count_reg + CW'(1);
                    if (!is_space && (phase_reg != PH_AFTER)
                            && (len_reg < LW'(NAME_LEN))) begin
                        for (int k = 0; k < NAME_BYTES_MAX; k++) begin
                            if (k == int'(len_reg)) begin
                                word_next[8*k +: 8] = in_byte;
                            end
                        end
                        len_next = len_reg + LW'(1);
                    end
                end else begin
                    item.dropped = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_BEFORE;
            count_reg <= '0;
            len_reg   <= '0;
            word_reg  <= '0;
        end else begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            len_reg   <= len_next;
            word_reg  <= word_next;
        end
    end

endmodule

>>> design/lcwm_queue.sv
// ----------------------------------------------------------------------------
// lcwm_queue: short item queue between front end and back end
// A small circular buffer that lets either side stall without the other.
// ----------------------------------------------------------------------------
module lcwm_queue
    import lcwm_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        push_valid,
    output logic        push_ready,
    input  front_item_t push_item,
    output logic        pop_valid,
    input  logic        pop_ready,
    output front_item_t pop_item
);

    localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(QUEUE_DEPTH + 1);

    front_item_t     entry_reg [QUEUE_DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]   fill_reg, fill_next;
    logic            push;
    logic            pop;

    assign push_ready = (fill_reg != NW'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            fill_next = fill_reg + NW'(1);
        end else if (pop && !push) begin
            fill_next = fill_reg - NW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

>>> design/lcwm_back.sv
// ----------------------------------------------------------------------------
// lcwm_back: name compare and result register
// Compares the word of a finished line with the active names, picks the
// lowest matching index and holds the result until it is taken.
// ----------------------------------------------------------------------------
module lcwm_back
    import lcwm_pkg::*;
#(
    parameter int NAME_LEN = NAME_LEN_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [2:0]  cmd_count,
    input  name_array_t names,
    input  logic        item_valid,
    output logic        item_ready,
    input  front_item_t item,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_line_event,
    output logic [2:0]  m_match_index,
    output logic        m_byte_dropped
);

    // Compare like strncmp: stop at the first difference or a shared zero.
    function automatic logic name_match(input logic [NAME_W-1:0] word,
                                        input logic [NAME_W-1:0] name);
        logic same;
        logic done;
        same = 1'b1;
        done = 1'b0;
        for (int k = 0; k < NAME_BYTES_MAX; k++) begin
            if (!done && (k < NAME_LEN)) begin
                if (word[8*k +: 8] != name[8*k +: 8]) begin
                    same = 1'b0;
                    done = 1'b1;
                end else if (word[8*k +: 8] == 8'h00) begin
                    done = 1'b1;
                end
            end
        end
        return same;
    endfunction

    logic                 valid_reg;
    line_event_t          event_reg, event_next;
    logic [2:0]           index_reg, index_next;
    logic                 dropped_reg;
    logic [NUM_NAMES-1:0] hit;
    logic                 any_hit;
    logic [2:0]           hit_index;
    logic                 pop;

    assign item_ready = !valid_reg || m_ready;
    assign pop        = item_valid && item_ready;

    always_comb begin
        for (int i = 0; i < NUM_NAMES; i++) begin
            hit[i] = (3'(i) < cmd_count) && name_match(item.word, names[i]);
        end
    end

    always_comb begin
        any_hit   = 1'b0;
        hit_index = '0;
        for (int i = NUM_NAMES - 1; i >= 0; i--) begin
            if (hit[i]) begin
                any_hit   = 1'b1;
                hit_index = 3'(i);
            end
        end
    end

    always_comb begin
        event_next = EV_NONE;
        index_next = '0;
        if (item.line_end) begin
            if (!item.has_word) begin
                event_next = EV_EMPTY;
            end else if (any_hit) begin
                event_next = EV_MATCH;
                index_next = hit_index;
            end else begin
                event_next = EV_NOMATCH;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (item_ready) begin
            valid_reg <= item_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            event_reg   <= event_next;
            index_reg   <= index_next;
            dropped_reg <= item.dropped;
        end
    end

    assign m_valid        = valid_reg;
    assign m_line_event   = event_reg;
    assign m_match_index  = index_reg;
    assign m_byte_dropped = dropped_reg;

endmodule

>>> dv/lcwm_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// lcwm_scoreboard_pkg: result prediction and checking for the word matcher
// Keeps its own copy of the line state and of the registers. It predicts the
// result of every accepted byte and compares the results in order.
// ----------------------------------------------------------------------------
package lcwm_scoreboard_pkg;
    import lcwm_pkg::*;

    typedef struct {
        line_event_t line_event;
        logic [2:0]  match_index;
        logic        byte_dropped;
    } line_result_t;

    class line_scoreboard;
        logic [7:0]        terminator;
        logic [2:0]        cmd_count;
        logic [NAME_W-1:0] names [NUM_NAMES];

        word_phase_t       phase;
        int unsigned       stored_bytes;
        logic [NAME_W-1:0] word_chars;
        int unsigned       word_len;

        line_result_t      pending_results [$];
        int unsigned       mismatches;

        function new();
            terminator = TERMINATOR_RST;
            cmd_count  = '0;
            foreach (names[i]) names[i] = '0;
            mismatches = 0;
            clear_line();
        endfunction

        function void clear_line();
            phase        = PH_BEFORE;
            stored_bytes = 0;
            word_chars   = '0;
            word_len     = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
            if (index == REG_TERMINATOR) begin
                terminator = data[7:0];
            end else if (index == REG_CMD_COUNT) begin
                cmd_count = data[2:0];
            end else begin
                names[index - REG_NAME_0] = data;
            end
        endfunction

        // Compare like strncmp on NAME_LEN characters: a zero byte ends it.
        function bit word_equals(logic [NAME_W-1:0] name);
            bit same;
            bit done;
            same = 1'b1;
            done = 1'b0;
            for (int k = 0; k < NAME_LEN_DEF; k++) begin
                if (!done) begin
                    if (word_chars[8*k +: 8] != name[8*k +: 8]) begin
                        same = 1'b0;
                        done = 1'b1;
                    end else if (word_chars[8*k +: 8] == 8'h00) begin
                        done = 1'b1;
                    end
                end
            end
            return same;
        endfunction

        function void note_byte(logic [7:0] rx);
            line_result_t res;
            int           used;
            res.line_event   = EV_NONE;
            res.match_index  = '0;
            res.byte_dropped = 1'b0;
            if (rx == terminator) begin
                if (phase == PH_BEFORE) begin
                    res.line_event = EV_EMPTY;
                end else begin
                    used = (cmd_count > NUM_NAMES) ? NUM_NAMES : cmd_count;
                    res.line_event = EV_NOMATCH;
                    // Walk down so that the lowest matching index is kept.
                    for (int i = used - 1; i >= 0; i--) begin
                        if (word_equals(names[i])) begin
                            res.line_event  = EV_MATCH;
                            res.match_index = i[2:0];
                        end
                    end
                end
                clear_line();
            end else if (rx >= PRINT_LOW && rx <= PRINT_HIGH) begin
                if (stored_bytes < LINE_BUFFER_LEN_DEF) begin
                    stored_bytes++;
                    if (rx == SPACE_CHAR) begin
                        if (phase == PH_INSIDE) phase = PH_AFTER;
                    end else if (phase != PH_AFTER) begin
                        phase = PH_INSIDE;
                        if (word_len < NAME_LEN_DEF) begin
                            word_chars[8*word_len +: 8] = rx;
                            word_len++;
                        end
                    end
                end else begin
                    res.byte_dropped = 1'b1;
                end
            end
            pending_results.push_back(res);
        endfunction

        function void check_result(logic [1:0] ev, logic [2:0] idx, logic dropped);
            line_result_t want;
            if (pending_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: unexpected result event=%0d index=%0d dropped=%0b",
                             $time, ev, idx, dropped);
                return;
            end
            want = pending_results.pop_front();
            if (ev !== want.line_event || idx !== want.match_index ||
                dropped !== want.byte_dropped) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"%0t: result mismatch: expected event=%0d index=%0d ",
                              "dropped=%0b, got event=%0d index=%0d dropped=%0b"},
                             $time, want.line_event, want.match_index,
                             want.byte_dropped, ev, idx, dropped);
            end
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        function bit all_matched();
            if (pending_results.size() != 0) begin
                $display("%0d expected results never arrived", pending_results.size());
                mismatches += pending_results.size();
            end
            return mismatches == 0;
        endfunction
    endclass

endpackage

>>> dv/line_command_word_matcher_top_test.sv
// ----------------------------------------------------------------------------
// line_command_word_matcher_top_test: testbench of the command word matcher
// Feeds byte streams made of command lines, long lines and noise through the
// block under several register settings and flow control patterns, and
// checks every result against a scoreboard that predicts it per byte.
// ----------------------------------------------------------------------------
module line_command_word_matcher_top_test
    import lcwm_pkg::*, lcwm_scoreboard_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // A run of this many cycles with no transfer at all means a hang.
    localparam int unsigned QUIET_LIMIT  = 5000;
    localparam int          PHASE_COUNT  = 12;
    localparam int          PHASE_ITEMS  = 150;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [7:0]             s_rx_byte = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [1:0]             m_line_event;
    logic [2:0]             m_match_index;
    logic                   m_byte_dropped;

    line_scoreboard sb = new();

    // Flow control settings of the current phase, in percent.
    int unsigned src_idle_pct = 0;
    int unsigned sink_stall_pct = 0;
    int unsigned quiet_cycles = 0;
    int unsigned sent_count = 0;

    // Stimulus copy of the registers, used to build lines that hit the names.
    logic [7:0]        cur_term = TERMINATOR_RST;
    logic [2:0]        cur_count = '0;
    logic [NAME_W-1:0] cur_names [NUM_NAMES];

    line_command_word_matcher_top i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_rx_byte      (s_rx_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_line_event   (m_line_event),
        .m_match_index  (m_match_index),
        .m_byte_dropped (m_byte_dropped)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Result side: check each accepted result item and pick the next ready
    // level. Signals are read right at the edge, before any update lands.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            sb.check_result(m_line_event, m_match_index, m_byte_dropped);
        end
        m_ready <= aresetn && ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog on cycles in which nothing moves on any port.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_wr_en) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", quiet_cycles);
            $display("FAIL");
            $finish;
        end
    end

    // Present one byte, with random idle cycles ahead of it, and hold it
    // until the block takes it. Valid stays high afterwards so that back to
    // back items need no extra assignment in the same step.
    task automatic send_byte(input logic [7:0] rx);
        while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= rx;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_byte(rx);
        sent_count++;
    endtask

    task automatic send_text(input string text);
        for (int i = 0; i < text.len(); i++) send_byte(text[i]);
    endtask

    // Stop sending and wait until every predicted result has been checked.
    task automatic drain_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (sb.outstanding() != 0) @(posedge aclk);
    endtask

    // Write all eight registers from the stimulus copy. The block is idle
    // whenever this runs, since every byte gives exactly one result.
    task automatic program_registers();
        logic [CFG_DATA_W-1:0] data;
        for (int r = 0; r < 2 + NUM_NAMES; r++) begin
            if (r == REG_TERMINATOR) begin
                data = CFG_DATA_W'(cur_term);
            end else if (r == REG_CMD_COUNT) begin
                data = {$urandom, $urandom};
                data[2:0] = cur_count;
            end else begin
                data = cur_names[r - REG_NAME_0];
            end
            cfg_wr_en <= 1'b1;
            cfg_index <= r[CFG_INDEX_W-1:0];
            cfg_wdata <= data;
            @(posedge aclk);
            sb.write_reg(r[CFG_INDEX_W-1:0], data);
        end
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [NAME_W-1:0] pack_name(input string text);
        logic [NAME_W-1:0] packed_name;
        packed_name = '0;
        for (int i = 0; i < text.len() && i < NAME_BYTES_MAX; i++) begin
            packed_name[8*i +: 8] = text[i];
        end
        return packed_name;
    endfunction

    // A printable character that is neither a space nor the terminator.
    function automatic logic [7:0] pick_char();
        logic [7:0] c;
        c = 8'($urandom_range(8'h7E, 8'h21));
        if (c == cur_term) c = (c == 8'h21) ? 8'h22 : 8'h21;
        return c;
    endfunction

    // Names are mostly plain words so that typed lines can hit them; the
    // rest are empty, all ones, raw random or carry a zero byte inside.
    function automatic logic [NAME_W-1:0] make_name();
        logic [NAME_W-1:0] nm;
        int                len;
        int                pick;
        nm   = '0;
        pick = $urandom_range(99);
        if (pick < 70) begin
            len = $urandom_range(NAME_BYTES_MAX, 1);
            for (int i = 0; i < len; i++) nm[8*i +: 8] = pick_char();
        end else if (pick < 77) begin
            nm = '1;
        end else if (pick < 83) begin
            nm = '0;
        end else if (pick < 90) begin
            nm = {$urandom, $urandom};
        end else begin
            len = $urandom_range(3, 1);
            for (int i = 0; i < NAME_BYTES_MAX; i++) begin
                if (i != len) nm[8*i +: 8] = pick_char();
            end
        end
        return nm;
    endfunction

    // Build one line and send it. Most lines start with a configured name,
    // sometimes cut short or run on with extra characters, and may carry an
    // argument; the rest are unknown words, overlong lines, blank lines and
    // raw noise, which may run on without a terminator.
    task automatic send_random_line();
        logic [7:0]        line_q [$];
        logic [NAME_W-1:0] nm;
        int                kind;
        int                variant;
        int                n;
        int                lead;
        bit                stop;
        bit                add_term;
        kind     = $urandom_range(99);
        add_term = 1'b1;
        lead     = $urandom_range(3, 0);
        repeat (lead) line_q.push_back(SPACE_CHAR);
        if (kind < 60) begin
            nm      = cur_names[$urandom_range(NUM_NAMES - 1, 0)];
            variant = $urandom_range(3, 0);
            stop    = 1'b0;
            for (int k = 0; k < NAME_BYTES_MAX; k++) begin
                if (!stop) begin
                    if (nm[8*k +: 8] == 8'h00) stop = 1'b1;
                    else line_q.push_back(nm[8*k +: 8]);
                end
            end
            if (variant == 1 && line_q.size() > lead + 1) begin
                line_q.delete(line_q.size() - 1);
            end else if (variant == 2) begin
                repeat ($urandom_range(4, 1)) line_q.push_back(pick_char());
            end
            if ($urandom_range(1)) begin
                line_q.push_back(SPACE_CHAR);
                repeat ($urandom_range(6, 1)) line_q.push_back(pick_char());
            end
        end else if (kind < 75) begin
            repeat ($urandom_range(10, 1)) line_q.push_back(pick_char());
            if ($urandom_range(1)) begin
                line_q.push_back(SPACE_CHAR);
                repeat ($urandom_range(5, 1)) line_q.push_back(pick_char());
            end
        end else if (kind < 87) begin
            // Mostly long enough to fill the line buffer and lose bytes.
            n = $urandom_range(44, 28);
            repeat (n) line_q.push_back(($urandom_range(4) == 0) ? SPACE_CHAR : pick_char());
        end else if (kind < 95) begin
            repeat ($urandom_range(12, 1)) line_q.push_back(8'($urandom_range(255)));
            add_term = $urandom_range(1);
        end
        if (add_term) line_q.push_back(cur_term);
        foreach (line_q[i]) send_byte(line_q[i]);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed lines: newline terminator, all six names in use, with a
        // duplicate name, a full eight character name, a name with a zero
        // byte inside it and an all ones name.
        cur_term     = 8'h0A;
        cur_count    = 3'd6;
        cur_names[0] = pack_name("set");
        cur_names[1] = pack_name("get");
        cur_names[2] = pack_name("abcdefgh");
        cur_names[3] = pack_name("s") | (pack_name("zz") << 16);
        cur_names[4] = pack_name("get");
        cur_names[5] = '1;
        program_registers();
        // Control and high bytes are ignored, so this line is empty.
        send_byte(8'h00);
        send_byte(8'hFF);
        send_byte(8'h7F);
        send_byte(8'h80);
        send_byte(8'h1F);
        send_byte(8'h0A);
        // Leading space, and two names equal: the lower index wins.
        send_text(" get\n");
        // A word longer than eight characters matches on its first eight.
        send_text("abcdefghij\n");
        // The zero byte ends the compare, so the bytes behind it do not count.
        send_text("s\n");
        send_text("zz\n");
        drain_results();

        // A printable terminator ends the line before it could be stored,
        // and a count of seven acts as six.
        cur_term  = 8'h3B;
        cur_count = 3'd7;
        program_registers();
        send_text("set;");
        send_text("~s;");
        drain_results();

        // Random phases. Each one picks new registers and a flow control
        // pattern; the extremes of the terminator and the count come round
        // in turn.
        for (int ph = 0; ph < PHASE_COUNT; ph++) begin
            case (ph % 6)
                0: cur_term = 8'h0A;
                1: cur_term = 8'h00;
                2: cur_term = 8'hFF;
                3: cur_term = 8'h3B;
                4: cur_term = SPACE_CHAR;
                default: cur_term = 8'($urandom_range(255));
            endcase
            case (ph % 4)
                0: cur_count = 3'd6;
                1: cur_count = 3'd0;
                2: cur_count = 3'd7;
                default: cur_count = 3'($urandom_range(7));
            endcase
            foreach (cur_names[i]) cur_names[i] = make_name();
            case (ph % 4)
                0: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
                1: begin
                    src_idle_pct   = 70;
                    sink_stall_pct = 0;
                end
                2: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 70;
                end
                default: begin
                    src_idle_pct   = 13;
                    sink_stall_pct = 13;
                end
            endcase
            program_registers();
            sent_count = 0;
            while (sent_count < PHASE_ITEMS) begin
                send_random_line();
                // Now and then let the pipeline run dry in the middle of a
                // phase.
                if ($urandom_range(99) < 3) drain_results();
            end
            drain_results();
        end

        src_idle_pct   = 0;
        sink_stall_pct = 0;
        // Give a late or extra result time to show up before judging.
        repeat (10) @(posedge aclk);
        if (sb.all_matched()) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
